/* rtl/core/rpth_pkg.sv */
// Shared types and constants for the controller word to gamepad report block.
// Used by rpth_csr, rpth_update and retro_pad_to_hid_report.
`default_nettype none

package rpth_pkg;

   // pad type carried with each item
   localparam logic [1:0] OP_GAME_PAD  = 2'd0;
   localparam logic [1:0] OP_POWER_PAD = 2'd1;
   localparam logic [1:0] OP_LIGHT_GUN = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_AS_BUTTON  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PP_COMPACT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_BUTTON_NUMBER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_PERIOD_MS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_PERIOD_MS = 3'd4;
   localparam int unsigned CSR_DATA_W = 16;

   // hat codes
   localparam logic [3:0] HAT_CENTER = 4'd0;
   localparam logic [3:0] HAT_N      = 4'd1;
   localparam logic [3:0] HAT_NE     = 4'd2;
   localparam logic [3:0] HAT_E      = 4'd3;
   localparam logic [3:0] HAT_SE     = 4'd4;
   localparam logic [3:0] HAT_S      = 4'd5;
   localparam logic [3:0] HAT_SW     = 4'd6;
   localparam logic [3:0] HAT_W      = 4'd7;
   localparam logic [3:0] HAT_NW     = 4'd8;

   // fixed button numbers
   localparam logic [3:0] BTN_A      = 4'd1;
   localparam logic [3:0] BTN_SELECT = 4'd5;

   localparam int unsigned PP_KEYS = 12;
   // power pad key n (on word bit 11-n) to button number
   localparam logic [3:0] PP_MAP [PP_KEYS] = '{
      4'd1, 4'd0, 4'd4, 4'd8, 4'd5, 4'd9, 4'd10, 4'd6, 4'd3, 4'd2, 4'd11, 4'd7
   };
   // button number modulo 6, for the compressed scheme
   localparam logic [2:0] PP_GROUP [PP_KEYS] = '{
      3'd1, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd4, 3'd0, 3'd3, 3'd2, 3'd5, 3'd1
   };
   // button number above 5 means start, otherwise select
   localparam logic PP_START [PP_KEYS] = '{
      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1
   };

   localparam logic [15:0] PREV_WORD_RESET = 16'hFFFF;

   typedef struct packed {
      logic        select_as_button;
      logic        pp_compact;
      logic [3:0]  b_button_number;
      logic [15:0] light_period_ms;
      logic [15:0] trigger_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] pad_data;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [15:0] previous_word;
      logic [15:0] held_buttons;
      logic        start_state;
      logic        select_state;
      logic [3:0]  hat_state;
      logic        trigger_auto_released;
      logic [31:0] trigger_stamp;
      logic [31:0] light_stamp;
   } state_type;

   typedef struct packed {
      logic        report_sent;
      logic [3:0]  hat_code;
      logic        select_pressed;
      logic        start_pressed;
      logic [15:0] button_mask;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/rpth_csr.sv */
// Configuration registers of the gamepad report block.
// Depends on rpth_pkg for register indexes and the cfg_type struct.
`default_nettype none

module rpth_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [rpth_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rpth_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rpth_pkg::cfg_type                       cfg
);

   rpth_pkg::cfg_type cfg_ff;
   rpth_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rpth_pkg::CSR_SELECT_AS_BUTTON:  cfg_in.select_as_button  = csr_wdata[0];
            rpth_pkg::CSR_PP_COMPACT:        cfg_in.pp_compact        = csr_wdata[0];
            rpth_pkg::CSR_B_BUTTON_NUMBER:   cfg_in.b_button_number   = csr_wdata[3:0];
            rpth_pkg::CSR_LIGHT_PERIOD_MS:   cfg_in.light_period_ms   = csr_wdata;
            rpth_pkg::CSR_TRIGGER_PERIOD_MS: cfg_in.trigger_period_ms = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.select_as_button  <= 1'b0;
         cfg_ff.pp_compact        <= 1'b0;
         cfg_ff.b_button_number   <= 4'd2;
         cfg_ff.light_period_ms   <= 16'd100;
         cfg_ff.trigger_period_ms <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/core/rpth_update.sv */
// Next-state logic: applies one controller word to the report state.
// Purely combinational; depends on rpth_pkg for types, tables and codes.
`default_nettype none

module rpth_update (
   input  wire rpth_pkg::cfg_type   cfg,
   input  wire rpth_pkg::state_type state,
   input  wire rpth_pkg::item_type  item,
   output rpth_pkg::state_type      state_next,
   output rpth_pkg::result_type     result
);

   function automatic logic [3:0] hat_of(input logic [3:0] dir);
      logic [3:0] code;
      begin
         unique case (dir)
            4'h7:    code = rpth_pkg::HAT_N;
            4'h6:    code = rpth_pkg::HAT_NE;
            4'hE:    code = rpth_pkg::HAT_E;
            4'hA:    code = rpth_pkg::HAT_SE;
            4'hB:    code = rpth_pkg::HAT_S;
            4'h9:    code = rpth_pkg::HAT_SW;
            4'hD:    code = rpth_pkg::HAT_W;
            4'h5:    code = rpth_pkg::HAT_NW;
            default: code = rpth_pkg::HAT_CENTER;
         endcase
         return code;
      end
   endfunction

   logic [15:0] d;
   logic [15:0] p;
   logic [15:0] press;
   logic [15:0] release_e;
   logic        sent;
   logic        found;
   logic [2:0]  grp;
   logic [31:0] light_age;
   logic [31:0] trig_age;
   logic        light_late;
   logic        trig_late;
   rpth_pkg::state_type s;

   assign d         = item.pad_data;
   assign p         = state.previous_word;
   assign press     = ~d & p;
   assign release_e = d & ~p;
   assign light_age = item.now_ms - state.light_stamp;
   assign trig_age  = item.now_ms - state.trigger_stamp;
   assign light_late = light_age > {16'd0, cfg.light_period_ms};
   assign trig_late  = trig_age > {16'd0, cfg.trigger_period_ms};

   always_comb begin
      s     = state;
      sent  = 1'b0;
      found = 1'b0;
      grp   = 3'd0;
      unique case (item.op)
         rpth_pkg::OP_GAME_PAD: begin
            if (d[7:0] != p[7:0]) begin
               sent = 1'b1;
               // A, B, select, start in that order
               if (press[7])     s.held_buttons[rpth_pkg::BTN_A] = 1'b1;
               if (release_e[7]) s.held_buttons[rpth_pkg::BTN_A] = 1'b0;
               if (press[6])     s.held_buttons[cfg.b_button_number] = 1'b1;
               if (release_e[6]) s.held_buttons[cfg.b_button_number] = 1'b0;
               if (press[5] || release_e[5]) begin
                  if (cfg.select_as_button)
                     s.held_buttons[rpth_pkg::BTN_SELECT] = press[5];
                  else
                     s.select_state = press[5];
               end
               if (press[4] || release_e[4]) s.start_state = press[4];
               if (d[3:0] != p[3:0]) s.hat_state = hat_of(d[3:0]);
            end
         end
         rpth_pkg::OP_POWER_PAD: begin
            if (cfg.pp_compact) begin
               sent = 1'b1;
               for (int n = 0; n < rpth_pkg::PP_KEYS; n++) begin
                  if (!found && press[rpth_pkg::PP_KEYS-1-n]) begin
                     found = 1'b1;
                     grp   = rpth_pkg::PP_GROUP[n];
                     if (grp <= 3'd3) begin
                        s.hat_state = 4'd1 + {1'b0, grp[1:0], 1'b0};
                        s.held_buttons[rpth_pkg::BTN_A] = 1'b0;
                        s.held_buttons[cfg.b_button_number] = 1'b0;
                     end else if (grp == 3'd4) begin
                        s.held_buttons[rpth_pkg::BTN_A] = 1'b1;
                        s.hat_state = rpth_pkg::HAT_CENTER;
                        s.held_buttons[cfg.b_button_number] = 1'b0;
                     end else begin
                        s.held_buttons[cfg.b_button_number] = 1'b1;
                        s.held_buttons[rpth_pkg::BTN_A] = 1'b0;
                        s.hat_state = rpth_pkg::HAT_CENTER;
                     end
                     s.start_state = rpth_pkg::PP_START[n];
                     if (cfg.select_as_button)
                        s.held_buttons[rpth_pkg::BTN_SELECT] = !rpth_pkg::PP_START[n];
                     else
                        s.select_state = !rpth_pkg::PP_START[n];
                  end
               end
            end else if (d != p) begin
               sent = 1'b1;
               // map is a permutation, so every key drives its own button
               for (int n = 0; n < rpth_pkg::PP_KEYS; n++) begin
                  if (press[rpth_pkg::PP_KEYS-1-n])
                     s.held_buttons[rpth_pkg::PP_MAP[n]] = 1'b1;
                  if (release_e[rpth_pkg::PP_KEYS-1-n])
                     s.held_buttons[rpth_pkg::PP_MAP[n]] = 1'b0;
               end
            end
         end
         rpth_pkg::OP_LIGHT_GUN: begin
            sent = d != p;
            if (d[0] && !p[0]) begin
               s.light_stamp = item.now_ms;
               s.held_buttons[rpth_pkg::BTN_A] = 1'b0;
            end else if (!d[0] && p[0] && light_late) begin
               s.held_buttons[rpth_pkg::BTN_A] = 1'b1;
            end
            if (d[1] && !p[1]) begin
               s.trigger_auto_released = 1'b0;
               s.trigger_stamp = item.now_ms;
               s.held_buttons[cfg.b_button_number] = 1'b1;
            end else if (d[1] && p[1] && !state.trigger_auto_released && trig_late) begin
               s.trigger_auto_released = 1'b1;
               s.held_buttons[cfg.b_button_number] = 1'b0;
            end else if (!d[1] && p[1] && trig_late) begin
               s.trigger_auto_released = 1'b0;
               s.held_buttons[cfg.b_button_number] = 1'b0;
            end
         end
         default: ;
      endcase
      s.previous_word = d;
   end

   assign state_next = s;

   always_comb begin
      result.button_mask    = s.held_buttons;
      result.start_pressed  = s.start_state;
      result.select_pressed = s.select_state;
      result.hat_code       = s.hat_state;
      result.report_sent    = sent;
   end

endmodule

`default_nettype wire

/* rtl/core/retro_pad_to_hid_report.sv */
// Controller word to gamepad report state, top level.
// Instantiates rpth_csr and rpth_update; depends on rpth_pkg.
//
// Usage:
//   req channel: one sampled controller word per item. tuser carries the pad
//   type (game pad, power pad, light gun); tdata carries pad_data and now_ms.
//   rsp channel: exactly one result per item, in order: the current button
//   mask, start, select, hat code and a flag telling whether this item sends
//   a report.
//   csr port: a write is taken on any cycle with csr_write high; writes go
//   directly to the registers and should be made while the block is idle.
// Timing:
//   An item is held in an input register and the update logic runs between
//   that register and the result register, so the result is registered
//   before it is presented on rsp.
//   Throughput is one item per cycle while rsp_tready is high: the state
//   update is a single pass of edge logic and a 12-key priority pick.
// Reset: synchronous; clears both stages, the previous word to all ones,
//   all button, hat and timer state, and the registers to their defaults.
// Stall: while rsp_tready is low the result holds; one more item waits in
//   the input register, after which req_tready drops.
`default_nettype none

module retro_pad_to_hid_report (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,   // pad_data[15:0], now_ms[47:16]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // button_mask[15:0], start_pressed[16], select_pressed[17], hat_code[21:18],
   // report_sent[22], zero[23]
   output      logic [23:0] rsp_tdata,
   input  wire logic        csr_write,
   input  wire logic [rpth_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rpth_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rpth_pkg::cfg_type    cfg;
   rpth_pkg::state_type  state_ff;
   rpth_pkg::state_type  state_in;
   rpth_pkg::item_type   item_ff;
   rpth_pkg::result_type rsp_ff;
   rpth_pkg::result_type rsp_in;
   logic                 s1_valid_ff;
   logic                 rsp_valid_ff;
   logic                 s1_go;
   logic                 req_take;

   rpth_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpth_update u_update (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.previous_word         <= rpth_pkg::PREV_WORD_RESET;
         state_ff.held_buttons          <= 16'd0;
         state_ff.start_state           <= 1'b0;
         state_ff.select_state          <= 1'b0;
         state_ff.hat_state             <= rpth_pkg::HAT_CENTER;
         state_ff.trigger_auto_released <= 1'b0;
         state_ff.trigger_stamp         <= 32'd0;
         state_ff.light_stamp           <= 32'd0;
      end else begin
         if (req_take)
            s1_valid_ff <= 1'b1;
         else if (s1_go)
            s1_valid_ff <= 1'b0;
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op       <= req_tuser;
         item_ff.pad_data <= req_tdata[15:0];
         item_ff.now_ms   <= req_tdata[47:16];
      end
      if (s1_go)
         rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   a_hat_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.hat_state <= rpth_pkg::HAT_NW)
      else $error("hat state out of range");

   a_prev_reset: assert property (@(posedge clock)
      reset |=> state_ff.previous_word == rpth_pkg::PREV_WORD_RESET)
      else $error("previous word not restored by reset");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(state_ff))
      else $error("state changed without an item");

   a_unused_no_report: assert property (@(posedge clock) disable iff (reset)
      (s1_go && item_ff.op == rpth_pkg::OP_UNUSED) |=> !rsp_ff.report_sent)
      else $error("unused pad type sent a report");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled with room available");

endmodule

`default_nettype wire
